### rtl/terminal_text_wrap_filter_assert.svh
// ----------------------------------------------------------------------------
// Terminal text wrap filter assertion macros
// Shared concurrent assertion forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_TEXT_WRAP_FILTER_ASSERT_SVH
`define TERMINAL_TEXT_WRAP_FILTER_ASSERT_SVH

// same-cycle implication
`define TTWF_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttwf assertion failed");

// next-cycle implication
`define TTWF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttwf assertion failed");

`endif

### rtl/ttwf_pkg.sv
// ----------------------------------------------------------------------------
// Terminal text wrap filter package
// Types, character codes and register definitions shared by the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttwf_pkg;

   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam int COL_W = 10;
   localparam int ESC_W = 2;
   localparam logic [ESC_W-1:0] ESC_LEN = 2'd3;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [1:0] CSR_WRAP_ENABLE   = 2'd0;
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_PROMPT_LENGTH = 2'd2;

   localparam logic [7:0] SCREEN_WIDTH_RST  = 8'd80;

   typedef enum logic [1:0] {
      CMD_PASS,
      CMD_NEWLINE,
      CMD_WRAP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic       wrap_enable;
      logic [7:0] screen_width;
      logic [7:0] prompt_length;
   } cfg_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

`default_nettype wire

### rtl/ttwf_if.sv
// ----------------------------------------------------------------------------
// Terminal text wrap filter channels
// Valid/ready request and response channels of the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ttwf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       message_start;

   modport source (output valid, output in_byte, output message_start, input ready);
   modport sink   (input valid, input in_byte, input message_start, output ready);
endinterface

interface ttwf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

### rtl/ttwf_queue.sv
// ----------------------------------------------------------------------------
// Terminal text wrap filter command queue
// Small FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "terminal_text_wrap_filter_assert.svh"

module ttwf_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire ttwf_pkg::cmd_type       push_cmd,
   input  wire logic                    pop,
   output ttwf_pkg::cmd_type            head_cmd,
   output ttwf_pkg::q_status_type       q_status
);

   ttwf_pkg::cmd_type               mem [ttwf_pkg::QDEPTH];
   logic [ttwf_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ttwf_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ttwf_pkg::QCNT_W-1:0]     count_ff,  count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd       = mem[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == ttwf_pkg::QCNT_W'(ttwf_pkg::QDEPTH));

   `TTWF_ASSERT_NOW(a_no_overflow, clock, reset, push, !q_status.full || pop)
   `TTWF_ASSERT_NOW(a_no_underflow, clock, reset, pop, !q_status.empty)
   `TTWF_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire

### rtl/ttwf_front.sv
// ----------------------------------------------------------------------------
// Terminal text wrap filter front end
// Accepts bytes, tracks column, escape and prompt state, issues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttwf_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ttwf_pkg::cfg_type       cfg,
   ttwf_req_if.sink                     req_chan,
   input  wire ttwf_pkg::q_status_type  q_status,
   output logic                         push,
   output ttwf_pkg::cmd_type            push_cmd
);

   logic signed [ttwf_pkg::COL_W-1:0] col_ff, col_in, col_cur;
   logic [ttwf_pkg::ESC_W-1:0]        esc_ff, esc_in, esc_cur;
   logic                              pp_ff, pp_in, pp_cur;

   logic signed [ttwf_pkg::COL_W:0]   col_ext, col_dec, col_inc, thr;
   logic [7:0]                        b;

   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && req_chan.ready;
   assign b              = req_chan.in_byte;

   always_comb begin
      col_cur = req_chan.message_start ? '0 : col_ff;
      esc_cur = req_chan.message_start ? '0 : esc_ff;
      pp_cur  = req_chan.message_start ? 1'b1 : pp_ff;

      col_ext = {col_cur[ttwf_pkg::COL_W-1], col_cur};
      col_dec = col_ext - 11'sd4;
      col_inc = col_ext + 11'sd1;
      if (col_dec < -11'sd512) begin
         col_dec = -11'sd512;
      end
      if (col_inc > 11'sd511) begin
         col_inc = 11'sd511;
      end

      thr = $signed({3'b000, cfg.screen_width}) - 11'sd2;
      if (pp_cur && (cfg.prompt_length != 8'd0)) begin
         thr = thr - $signed({3'b000, cfg.prompt_length}) + 11'sd1;
      end

      col_in        = col_cur;
      esc_in        = esc_cur;
      pp_in         = pp_cur;
      push_cmd.kind = ttwf_pkg::CMD_PASS;
      push_cmd.data = b;

      if (esc_cur != '0) begin
         esc_in = esc_cur - 1'b1;
         if ((esc_cur == 2'd1) && (b == ttwf_pkg::CH_SEMI)) begin
            col_in = col_dec[ttwf_pkg::COL_W-1:0];
         end
      end else if (b == ttwf_pkg::CH_ESC) begin
         esc_in = ttwf_pkg::ESC_LEN;
      end else if (b == ttwf_pkg::CH_LF) begin
         push_cmd.kind = ttwf_pkg::CMD_NEWLINE;
         col_in        = '0;
      end else if (cfg.wrap_enable && (col_ext == thr)) begin
         push_cmd.kind = ttwf_pkg::CMD_WRAP;
         pp_in         = 1'b0;
         col_in        = 10'sd1;
      end else begin
         col_in = col_inc[ttwf_pkg::COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         esc_ff <= '0;
         pp_ff  <= 1'b1;
      end else if (push) begin
         col_ff <= col_in;
         esc_ff <= esc_in;
         pp_ff  <= pp_in;
      end
   end

endmodule

`default_nettype wire

### rtl/ttwf_back.sv
// ----------------------------------------------------------------------------
// Terminal text wrap filter back end
// Expands queued commands into response bytes through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "terminal_text_wrap_filter_assert.svh"

module ttwf_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ttwf_pkg::cmd_type       head_cmd,
   input  wire ttwf_pkg::q_status_type  q_status,
   output logic                         pop,
   ttwf_rsp_if.source                   rsp_chan
);

   logic [1:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       load_en;
   logic [7:0] cur_byte;
   logic       cur_last;

   always_comb begin
      cur_byte = head_cmd.data;
      cur_last = 1'b1;
      case (head_cmd.kind)
         ttwf_pkg::CMD_PASS: begin
            cur_byte = head_cmd.data;
            cur_last = 1'b1;
         end
         ttwf_pkg::CMD_NEWLINE: begin
            cur_byte = (step_ff == 2'd0) ? ttwf_pkg::CH_LF : ttwf_pkg::CH_CR;
            cur_last = (step_ff != 2'd0);
         end
         ttwf_pkg::CMD_WRAP: begin
            case (step_ff)
               2'd0:    cur_byte = ttwf_pkg::CH_LF;
               2'd1:    cur_byte = ttwf_pkg::CH_CR;
               2'd2:    cur_byte = ttwf_pkg::CH_SPACE;
               default: cur_byte = head_cmd.data;
            endcase
            cur_last = (step_ff == 2'd3);
         end
         default: begin
            cur_byte = head_cmd.data;
            cur_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      load_en  = !valid_ff || rsp_chan.ready;
      pop      = load_en && !q_status.empty && cur_last;
      step_in  = step_ff;
      valid_in = valid_ff && !rsp_chan.ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load_en && !q_status.empty) begin
         valid_in = 1'b1;
         byte_in  = cur_byte;
         last_in  = cur_last;
         step_in  = cur_last ? 2'd0 : step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.out_byte = byte_ff;
   assign rsp_chan.run_last = last_ff;

   `TTWF_ASSERT_NOW(a_step_has_cmd, clock, reset, step_ff != 2'd0, !q_status.empty)

endmodule

`default_nettype wire

### rtl/terminal_text_wrap_filter.sv
// A request passes through the command queue and then the output register.
// Throughput: one request per cycle while each yields one byte and the output is
//   ready; the back end emits one byte per ready cycle, 1, 2 or 4 per request.
// A four-entry command queue lets the front keep accepting while the back drains.
// Reset (synchronous, active high): column 0, no escape, prompt line active,
//   registers to wrap off, width 80, prompt 0; queue and output register empty.
// ----------------------------------------------------------------------------
// Terminal text wrap filter
// Line feed expansion, escape pass-through and automatic wrapping for a tty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module terminal_text_wrap_filter (
   input  wire logic       clock,
   input  wire logic       reset,
   ttwf_req_if.sink        req_chan,
   ttwf_rsp_if.source      rsp_chan,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   ttwf_pkg::cfg_type      cfg_ff, cfg_in;
   ttwf_pkg::cmd_type      push_cmd, head_cmd;
   ttwf_pkg::q_status_type q_status;
   logic                   push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ttwf_pkg::CSR_WRAP_ENABLE:   cfg_in.wrap_enable   = csr_wdata[0];
            ttwf_pkg::CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata;
            ttwf_pkg::CSR_PROMPT_LENGTH: cfg_in.prompt_length = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wrap_enable   <= 1'b0;
         cfg_ff.screen_width  <= ttwf_pkg::SCREEN_WIDTH_RST;
         cfg_ff.prompt_length <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ttwf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   ttwf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   ttwf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
